// ----- sv/lidar_range_image_projection_assert.svh -----
// Assertion macros for the range image projection checker.
// No dependencies; pulled in by the checker file.
`ifndef LIDAR_RANGE_IMAGE_PROJECTION_ASSERT_SVH
`define LIDAR_RANGE_IMAGE_PROJECTION_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define LRIP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define LRIP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lrip_pkg.sv -----
// Package for the lidar range image projection: sizes, fixed-point constants,
// CORDIC step types and functions. No dependencies.
`timescale 1ns / 1ps

package lrip_pkg;

   // Image geometry and CORDIC depth
   localparam int ROWS         = 16;
   localparam int COLUMNS      = 1800;
   localparam int CORDIC_STEPS = 20;

   // Field widths
   localparam int PW     = 20;    // coordinate width
   localparam int RING_W = 4;
   localparam int ROW_W  = 4;
   localparam int COL_W  = 11;
   localparam int CELL_W = 15;
   localparam int RNG_W  = 20;
   localparam int CSR_W  = 20;

   // Datapath widths
   localparam int CW     = 34;               // CORDIC x/y
   localparam int AW     = 28;               // angle, 2^-16 degree
   localparam int NUM_W  = 42;               // (H - 90 deg) * COLUMNS
   localparam int VW     = NUM_W - 16;       // column quotient numerator
   localparam int QW     = VW - 8 + 1;       // column quotient, one spare bit
   localparam int NW     = 30;               // elevation plus offset
   localparam int ND_W   = NW - 9;           // elevation offset in 1 deg/256 units
   localparam int RB     = $clog2(ROWS);     // row quotient bits
   localparam int DW     = ND_W + 1;         // divider remainder width
   localparam int CLW    = QW + 13;          // signed column before wrap

   // Fixed-point constants
   localparam logic signed [AW-1:0] ANG_HALF    = AW'(180 * 65536);
   localparam logic signed [NUM_W-1:0] ANG_QUARTER = NUM_W'(90 * 65536);
   localparam logic signed [NUM_W-1:0] COLS_S   = NUM_W'(COLUMNS);
   localparam logic [63:0] GAIN      = 64'd2608131496;
   localparam logic [63:0] RND_MAG   = 64'd1 << 31;
   localparam logic [63:0] RND_RANGE = (64'd1 << 31) + (64'd1 << 39);
   localparam logic [NUM_W-1:0] RND_COL = NUM_W'(180 * 65536);   // half of 360 deg
   localparam int DEG_FULL = 360;
   localparam logic [63:0] RECIP = (64'd1 << VW) / DEG_FULL;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_USE_RING     = 2'd0,
      CSR_MIN_RANGE    = 2'd1,
      CSR_BOTTOM_ANGLE = 2'd2,
      CSR_VERTICAL_RES = 2'd3
   } csr_idx_type;

   // One CORDIC stage: vector, accumulated angle, and an angle carried along
   typedef struct packed {
      logic signed [CW-1:0] cx;
      logic signed [CW-1:0] cy;
      logic signed [AW-1:0] ca;
      logic signed [AW-1:0] ch;
   } cord_type;

   // Point carried down the pipeline
   typedef struct packed {
      logic signed [PW-1:0] x;
      logic signed [PW-1:0] y;
      logic signed [PW-1:0] z;
      logic [RING_W-1:0]    ring;
   } pt_type;

   // atan(2^-i) in 2^-16 degree
   function automatic logic signed [AW-1:0] atan_lut(input int unsigned idx);
      case (idx)
         0:  return AW'(2949120);
         1:  return AW'(1740967);
         2:  return AW'(919879);
         3:  return AW'(466945);
         4:  return AW'(234379);
         5:  return AW'(117304);
         6:  return AW'(58666);
         7:  return AW'(29335);
         8:  return AW'(14668);
         9:  return AW'(7334);
         10: return AW'(3667);
         11: return AW'(1833);
         12: return AW'(917);
         13: return AW'(458);
         14: return AW'(229);
         15: return AW'(115);
         16: return AW'(57);
         17: return AW'(29);
         18: return AW'(14);
         19: return AW'(7);
         20: return AW'(4);
         21: return AW'(2);
         22: return AW'(1);
         default: return '0;
      endcase
   endfunction

   // Fold the left half plane onto the right half before vectoring
   function automatic cord_type cord_prerot(input logic signed [CW-1:0] vx,
                                            input logic signed [CW-1:0] vy);
      cord_type c;
      c.ch = '0;
      if (vx < 0) begin
         c.cx = -vx;
         c.cy = -vy;
         c.ca = (vy >= 0) ? ANG_HALF : -ANG_HALF;
      end else begin
         c.cx = vx;
         c.cy = vy;
         c.ca = '0;
      end
      return c;
   endfunction

   // One vectoring micro-rotation toward y = 0
   function automatic cord_type cord_iter(input cord_type c, input int unsigned idx);
      cord_type n;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      n  = c;
      dx = c.cy >>> idx;
      dy = c.cx >>> idx;
      if (c.cy >= 0) begin
         n.cx = c.cx + dx;
         n.cy = c.cy - dy;
         n.ca = c.ca + atan_lut(idx);
      end else begin
         n.cx = c.cx - dx;
         n.cy = c.cy + dy;
         n.ca = c.ca - atan_lut(idx);
      end
      return n;
   endfunction

endpackage

// ----- sv/lidar_range_image_projection.sv -----
// Lidar range image projection: top level with the full pipeline.
// Depends on lrip_pkg.
`timescale 1ns / 1ps

// Usage
//  - req channel: one lidar point (pos_x/y/z in 1/256 m, ring) per transfer.
//  - rsp channel: row, column, cell index, coordinates and range of a kept
//    point; dropped points (outside the image, too near) give no transfer.
//  - csr port: write-only; write only while no point is in flight.
//  - Throughput: one point per cycle while req_stall is low. Two chained
//    pipelined CORDIC vectoring units make up most of the pipeline
//    between req and rsp.
//  - Stall: the output register is backed by one skid entry; req_stall rises
//    only once the skid entry is full, and then the whole pipeline holds.
//  - Reset: synchronous; empties the pipeline and restores register
//    defaults (use_ring 1, min_range 256, bottom_angle 3866, vertical_res 512).
module lidar_range_image_projection
   import lrip_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [PW-1:0]     req_pos_x,
   input  logic signed [PW-1:0]     req_pos_y,
   input  logic signed [PW-1:0]     req_pos_z,
   input  logic [RING_W-1:0]        req_ring,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [ROW_W-1:0]         rsp_row,
   output logic [COL_W-1:0]         rsp_column,
   output logic [CELL_W-1:0]        rsp_cell_index,
   output logic signed [PW-1:0]     rsp_out_x,
   output logic signed [PW-1:0]     rsp_out_y,
   output logic signed [PW-1:0]     rsp_out_z,
   output logic [RNG_W-1:0]         rsp_range,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [CSR_W-1:0]         csr_wdata
);

   localparam int S  = CORDIC_STEPS;
   localparam int NV = 2 * S + 7;     // stages before the final result stage

   // Configuration registers
   logic        use_ring_ff;
   logic [19:0] min_range_ff;
   logic [15:0] bottom_angle_ff;
   logic [15:0] vertical_res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ring_ff     <= 1'b1;
         min_range_ff    <= 20'd256;
         bottom_angle_ff <= 16'd3866;
         vertical_res_ff <= 16'd512;
      end else if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_USE_RING:     use_ring_ff     <= csr_wdata[0];
            CSR_MIN_RANGE:    min_range_ff    <= csr_wdata[19:0];
            CSR_BOTTOM_ANGLE: bottom_angle_ff <= csr_wdata[15:0];
            CSR_VERTICAL_RES: vertical_res_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Pipeline advance: everything moves unless the skid entry is occupied
   logic skid_v_ff;
   logic en;
   assign en        = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // Valid bits and point payload shift line
   logic [NV-1:0] v_ff;
   pt_type        pt_ff [NV];
   pt_type        pt_in;

   assign pt_in = '{x: req_pos_x, y: req_pos_y, z: req_pos_z, ring: req_ring};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[NV-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pt_ff[0] <= pt_in;
         for (int k = 1; k < NV; k++) begin
            pt_ff[k] <= pt_ff[k-1];
         end
      end
   end

   // Horizontal CORDIC: X = y*256, Y = x*256
   cord_type c1_ff [S+1];
   cord_type c1_start;
   logic signed [CW-1:0] in_cx;
   logic signed [CW-1:0] in_cy;

   assign in_cx    = $signed({{(CW-PW-8){req_pos_y[PW-1]}}, req_pos_y, 8'h00});
   assign in_cy    = $signed({{(CW-PW-8){req_pos_x[PW-1]}}, req_pos_x, 8'h00});
   assign c1_start = cord_prerot(in_cx, in_cy);

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff[0] <= c1_start;
         for (int i = 0; i < S; i++) begin
            c1_ff[i+1] <= cord_iter(c1_ff[i], i);
         end
      end
   end

   // Gain correction of the horizontal magnitude
   logic [31:0]          mag1;
   logic [63:0]          prod1_ff;
   logic signed [AW-1:0] hang1_ff;

   assign mag1 = c1_ff[S].cx[CW-1] ? '0 : c1_ff[S].cx[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         prod1_ff <= 64'(mag1) * GAIN;
         hang1_ff <= c1_ff[S].ca;
      end
   end

   // Elevation CORDIC: X = horizontal range, Y = z*256; horizontal angle rides along
   cord_type c2_ff [S+1];
   cord_type c2_start;
   logic [63:0] rsum1;
   logic [31:0] rh;
   logic signed [CW-1:0] rz;

   assign rsum1 = prod1_ff + RND_MAG;
   assign rh    = rsum1[63:32];
   assign rz    = $signed({{(CW-PW-8){pt_ff[S+1].z[PW-1]}}, pt_ff[S+1].z, 8'h00});

   always_comb begin
      c2_start    = cord_prerot($signed({{(CW-32){1'b0}}, rh}), rz);
      c2_start.ch = hang1_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c2_ff[0] <= c2_start;
         for (int i = 0; i < S; i++) begin
            c2_ff[i+1] <= cord_iter(c2_ff[i], i);
         end
      end
   end

   // Range product, column numerator and elevation offset
   logic [31:0]             mag2;
   logic signed [NUM_W-1:0] hdiff;
   logic [63:0]             prod2_ff;
   logic signed [NUM_W-1:0] num_ff;
   logic signed [NW-1:0]    n_ff;

   assign mag2  = c2_ff[S].cx[CW-1] ? '0 : c2_ff[S].cx[31:0];
   assign hdiff = NUM_W'(c2_ff[S].ch) - ANG_QUARTER;

   always_ff @(posedge clock) begin
      if (en) begin
         prod2_ff <= 64'(mag2) * GAIN;
         num_ff   <= hdiff * COLS_S;
         n_ff     <= NW'(c2_ff[S].ca) + $signed(NW'({bottom_angle_ff, 8'h00}));
      end
   end

   // Range rounding, column numerator scaling, row division
   logic [63:0]        rsum2;
   logic [NUM_W-1:0]   num_abs;
   logic [NUM_W-1:0]   vsum;
   logic [ND_W-1:0]    nd;
   logic [DW-1:0]      rem;
   logic [DW-1:0]      row_lim;
   logic [RB-1:0]      rq;
   logic               div_ok;
   logic [ROW_W-1:0]   row_sel;
   logic               row_ok;

   assign rsum2   = prod2_ff + RND_RANGE;
   assign num_abs = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign vsum    = num_abs + RND_COL;
   assign nd      = n_ff[NW-2:8];
   assign row_lim = DW'(vertical_res_ff) * DW'(ROWS);

   // Restoring divide, one quotient bit per step
   always_comb begin
      rem = DW'(nd);
      rq  = '0;
      for (int b = RB - 1; b >= 0; b--) begin
         if (rem >= (DW'(vertical_res_ff) << b)) begin
            rem   = rem - (DW'(vertical_res_ff) << b);
            rq[b] = 1'b1;
         end
      end
   end

   assign div_ok = !n_ff[NW-1] && (vertical_res_ff != '0) && (DW'(nd) < row_lim);

   always_comb begin
      if (use_ring_ff) begin
         row_sel = ROW_W'(pt_ff[2*S+3].ring);
         row_ok  = (32'(pt_ff[2*S+3].ring) < ROWS);
      end else begin
         row_sel = ROW_W'(rq);
         row_ok  = div_ok;
      end
   end

   logic [23:0]      range_e_ff;
   logic [VW-1:0]    vdiv_e_ff;
   logic             neg_e_ff;
   logic [ROW_W-1:0] row_e_ff;
   logic             rok_e_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         range_e_ff <= rsum2[63:40];
         vdiv_e_ff  <= vsum[NUM_W-1:16];
         neg_e_ff   <= num_ff[NUM_W-1];
         row_e_ff   <= row_sel;
         rok_e_ff   <= row_ok;
      end
   end

   // Reciprocal estimate of the column quotient, near-point test
   logic [63:0]      qprod;
   logic [QW-1:0]    qe_f_ff;
   logic [VW-1:0]    vdiv_f_ff;
   logic             neg_f_ff;
   logic [ROW_W-1:0] row_f_ff;
   logic             rok_f_ff;
   logic             near_ok_f_ff;
   logic [23:0]      range_f_ff;

   assign qprod = 64'(vdiv_e_ff) * RECIP;

   always_ff @(posedge clock) begin
      if (en) begin
         qe_f_ff      <= QW'(qprod >> VW);
         vdiv_f_ff    <= vdiv_e_ff;
         neg_f_ff     <= neg_e_ff;
         row_f_ff     <= row_e_ff;
         rok_f_ff     <= rok_e_ff;
         near_ok_f_ff <= range_e_ff >= 24'(min_range_ff);
         range_f_ff   <= range_e_ff;
      end
   end

   // Quotient correction, column and wrap
   logic [VW+1:0]         qrem;
   logic [QW-1:0]         qfix;
   logic signed [CLW-1:0] col_raw;
   logic signed [CLW-1:0] col_wrap;
   logic                  col_ok;

   assign qrem = (VW+2)'(vdiv_f_ff) - (VW+2)'(qe_f_ff) * (VW+2)'(DEG_FULL);
   assign qfix = (qrem >= (VW+2)'(DEG_FULL)) ? qe_f_ff + QW'(1) : qe_f_ff;

   always_comb begin
      if (neg_f_ff) begin
         col_raw = CLW'(COLUMNS / 2) + $signed({1'b0, qfix});
      end else begin
         col_raw = CLW'(COLUMNS / 2) - $signed({1'b0, qfix});
      end
      col_wrap = (col_raw >= CLW'(COLUMNS)) ? col_raw - CLW'(COLUMNS) : col_raw;
      col_ok   = (col_wrap >= 0) && (col_wrap < CLW'(COLUMNS));
   end

   logic [COL_W-1:0] col_h_ff;
   logic [ROW_W-1:0] row_h_ff;
   logic             ok_h_ff;
   logic [23:0]      range_h_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         col_h_ff   <= col_wrap[COL_W-1:0];
         row_h_ff   <= row_f_ff;
         ok_h_ff    <= rok_f_ff && near_ok_f_ff && col_ok;
         range_h_ff <= range_f_ff;
      end
   end

   // Final stage: keep/drop decision and cell address
   logic             fin_v_ff;
   logic [ROW_W-1:0] fin_row_ff;
   logic [COL_W-1:0] fin_col_ff;
   logic [CELL_W-1:0] fin_cell_ff;
   logic [RNG_W-1:0] fin_range_ff;
   pt_type           fin_pt_ff;
   logic [31:0]      cell_sum;

   assign cell_sum = 32'(col_h_ff) + 32'(row_h_ff) * 32'(COLUMNS);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
      end else if (en) begin
         fin_v_ff <= v_ff[NV-1] && ok_h_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_row_ff   <= row_h_ff;
         fin_col_ff   <= col_h_ff;
         fin_cell_ff  <= cell_sum[CELL_W-1:0];
         fin_range_ff <= range_h_ff[RNG_W-1:0];
         fin_pt_ff    <= pt_ff[NV-1];
      end
   end

   // Output register with one skid entry
   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [CELL_W-1:0] cidx;
      logic [RNG_W-1:0]  rng;
      pt_type            pt;
   } res_type;

   res_type fin_res;
   res_type out_ff;
   res_type skid_ff;
   logic    out_v_ff;
   logic    take;

   assign fin_res = '{row: fin_row_ff, col: fin_col_ff, cidx: fin_cell_ff,
                      rng: fin_range_ff, pt: fin_pt_ff};
   assign take    = out_v_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (take) begin
            skid_v_ff <= 1'b0;
         end
      end else if (fin_v_ff) begin
         if (out_v_ff && !take) begin
            skid_v_ff <= 1'b1;
         end
         out_v_ff <= 1'b1;
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_v_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (fin_v_ff) begin
         if (out_v_ff && !take) begin
            skid_ff <= fin_res;
         end else begin
            out_ff <= fin_res;
         end
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_row        = out_ff.row;
   assign rsp_column     = out_ff.col;
   assign rsp_cell_index = out_ff.cidx;
   assign rsp_range      = out_ff.rng;
   assign rsp_out_x      = out_ff.pt.x;
   assign rsp_out_y      = out_ff.pt.y;
   assign rsp_out_z      = out_ff.pt.z;

endmodule

// ----- sv/lrip_checker.sv -----
// Port-level checker for the lidar range image projection, bound to the top.
// Depends on lrip_pkg and lidar_range_image_projection_assert.svh.
`timescale 1ns / 1ps
`include "lidar_range_image_projection_assert.svh"

module lrip_checker
   import lrip_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic [ROW_W-1:0]     rsp_row,
   input logic [COL_W-1:0]     rsp_column,
   input logic [CELL_W-1:0]    rsp_cell_index
);

   logic [31:0] cell_sum;
   logic        cell_match;

   assign cell_sum   = 32'(rsp_column) + 32'(rsp_row) * 32'(COLUMNS);
   assign cell_match = (cell_sum[CELL_W-1:0] == rsp_cell_index);

   // A stalled result stays offered
   `LRIP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp valid dropped while stalled")

   // Cell address is consistent with row and column
   `LRIP_ASSERT_NOW(a_cell, clock, reset, rsp_valid, cell_match, "cell index mismatch")

   // Column always lands inside the image
   `LRIP_ASSERT_NOW(a_col_range, clock, reset, rsp_valid, 32'(rsp_column) < COLUMNS, "column out of range")

   // Input back-pressure only appears after a stalled output transfer
   `LRIP_ASSERT_NOW(a_stall_cause, clock, reset, $rose(req_stall), $past(rsp_valid && rsp_stall), "req stall without rsp stall")

endmodule

bind lidar_range_image_projection lrip_checker u_lrip_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_row        (rsp_row),
   .rsp_column     (rsp_column),
   .rsp_cell_index (rsp_cell_index)
);
